>>> hw/rtl/led_ring_spi_frame_encoder_macros.svh
// assertion macros for the led ring frame encoder
// no dependencies; included by the top level only
`ifndef LED_RING_SPI_FRAME_ENCODER_MACROS_SVH
`define LED_RING_SPI_FRAME_ENCODER_MACROS_SVH

// check on every rising edge outside reset
`define LRSFE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check on every rising edge, reset included
`define LRSFE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hw/rtl/lrsfe_pkg.sv
// constants, register codes and bit coding for the led ring frame encoder
// no dependencies; used by led_ring_spi_frame_encoder
package lrsfe_pkg;

   // frame layout
   localparam int unsigned PIXEL_COUNT     = 48;
   localparam int unsigned LATCH_BYTES     = 25;
   localparam int unsigned BYTES_PER_PIXEL = 15;
   localparam int unsigned FRAME_BYTES     = 1 + PIXEL_COUNT * BYTES_PER_PIXEL + LATCH_BYTES;

   // field widths
   localparam int unsigned POS_W    = 10;
   localparam int unsigned PIX_W    = 6;
   localparam int unsigned BYTE_W   = 4;
   localparam int unsigned COLOR_W  = 8;
   localparam int unsigned RING_W   = 6;
   localparam int unsigned ANGLE_W  = 9;
   localparam int unsigned PROD_W   = 15;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   // angle handling
   localparam int unsigned ANGLE_MAX   = 359;
   localparam int unsigned FULL_CIRCLE = 360;
   localparam int unsigned RING_RESET  = 48;

   // register codes, word index within the csr window
   typedef enum logic [2:0] {
      REG_FILL_GREEN = 3'd0,
      REG_FILL_RED   = 3'd1,
      REG_FILL_BLUE  = 3'd2,
      REG_MARK_GREEN = 3'd3,
      REG_MARK_RED   = 3'd4,
      REG_MARK_BLUE  = 3'd5,
      REG_RING_SIZE  = 3'd6,
      REG_ANGLE      = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] blue;
   } color_type;

   // byte idx of the 120-bit code stream: each color bit becomes 1 c c 0 0
   function automatic logic [7:0] encode_byte(input color_type color,
                                              input logic [BYTE_W-1:0] idx);
      logic [23:0]  bits;
      logic [119:0] stream;
      logic [119:0] shifted;
      bits = color;
      for (int k = 0; k < 24; k++) begin
         stream[119 - 5*k -: 5] = {1'b1, bits[23-k], bits[23-k], 2'b00};
      end
      shifted = stream << {idx, 3'b000};
      return shifted[119:112];
   endfunction

endpackage

>>> hw/rtl/led_ring_spi_frame_encoder.sv
// top level of the led ring frame encoder: csr block, frame counters, output register
// depends on lrsfe_pkg and led_ring_spi_frame_encoder_macros.svh

// Each transfer on the req channel yields exactly one frame byte on the rsp channel, via
// the output register, and a new request is taken in every cycle in which the register is
// empty or being emptied, so the block streams one byte per clock. A frame is 746 bytes: a
// zero byte, 48 pixels of 15 coded bytes (green, red, blue, msb first, each bit sent as
// 10000 or 11100) and 25 zero latch bytes; rsp_last_byte flags the final latch byte, after
// which the next request starts a new frame. req_restart forces byte zero at any point. The
// highlight pixel is floor(angle * ring_size / 360), angle clamped to 359; indices of 48 or
// more highlight nothing. Registers sit at byte addresses 4*i and take effect on the next
// request; change them only while no byte is in flight.
module led_ring_spi_frame_encoder (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [7:0]                        rsp_data_byte,
   output logic                              rsp_last_byte,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lrsfe_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lrsfe_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lrsfe_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import lrsfe_pkg::*;

   // configuration registers
   color_type            fill_ff;
   color_type            mark_ff;
   logic [RING_W-1:0]    ring_size_ff;
   logic [ANGLE_W-1:0]   angle_ff;

   // frame counters
   logic [POS_W-1:0]     frame_position_ff, frame_position_in;
   logic [PIX_W-1:0]     pixel_counter_ff, pixel_counter_in;
   logic [BYTE_W-1:0]    byte_within_pixel_ff, byte_within_pixel_in;

   // output register
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_xfer;
   logic                 csr_write;
   csr_reg_type          csr_index;
   logic [POS_W-1:0]     pos_c;
   logic [PIX_W-1:0]     pix_c;
   logic [BYTE_W-1:0]    byte_c;
   logic                 in_pixel_c;
   logic                 last_c;
   logic [ANGLE_W-1:0]   angle_clamped;
   logic [PROD_W-1:0]    mark_prod;
   logic [PROD_W-1:0]    pix_low;
   logic [PROD_W-1:0]    pix_high;
   logic                 is_mark;
   color_type            color_c;

   // handshakes
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_xfer   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_reg_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         mark_ff      <= '0;
         ring_size_ff <= RING_W'(RING_RESET);
         angle_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_FILL_GREEN: fill_ff.green <= csr_pwdata[COLOR_W-1:0];
            REG_FILL_RED:   fill_ff.red   <= csr_pwdata[COLOR_W-1:0];
            REG_FILL_BLUE:  fill_ff.blue  <= csr_pwdata[COLOR_W-1:0];
            REG_MARK_GREEN: mark_ff.green <= csr_pwdata[COLOR_W-1:0];
            REG_MARK_RED:   mark_ff.red   <= csr_pwdata[COLOR_W-1:0];
            REG_MARK_BLUE:  mark_ff.blue  <= csr_pwdata[COLOR_W-1:0];
            REG_RING_SIZE:  ring_size_ff  <= csr_pwdata[RING_W-1:0];
            REG_ANGLE:      angle_ff      <= csr_pwdata[ANGLE_W-1:0];
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (csr_index)
         REG_FILL_GREEN: csr_prdata = CSR_DATA_W'(fill_ff.green);
         REG_FILL_RED:   csr_prdata = CSR_DATA_W'(fill_ff.red);
         REG_FILL_BLUE:  csr_prdata = CSR_DATA_W'(fill_ff.blue);
         REG_MARK_GREEN: csr_prdata = CSR_DATA_W'(mark_ff.green);
         REG_MARK_RED:   csr_prdata = CSR_DATA_W'(mark_ff.red);
         REG_MARK_BLUE:  csr_prdata = CSR_DATA_W'(mark_ff.blue);
         REG_RING_SIZE:  csr_prdata = CSR_DATA_W'(ring_size_ff);
         REG_ANGLE:      csr_prdata = CSR_DATA_W'(angle_ff);
      endcase
   end

   // restart takes effect before the byte is produced
   assign pos_c  = req_restart ? '0 : frame_position_ff;
   assign pix_c  = req_restart ? '0 : pixel_counter_ff;
   assign byte_c = req_restart ? '0 : byte_within_pixel_ff;

   assign in_pixel_c = (pos_c != '0) && (pix_c < PIX_W'(PIXEL_COUNT));
   assign last_c     = pos_c >= POS_W'(FRAME_BYTES - 1);

   // highlight test: pix*360 <= angle*ring < (pix+1)*360
   assign angle_clamped = (angle_ff > ANGLE_W'(ANGLE_MAX)) ? ANGLE_W'(ANGLE_MAX) : angle_ff;
   assign mark_prod     = PROD_W'(angle_clamped) * PROD_W'(ring_size_ff);
   assign pix_low       = PROD_W'(pix_c) * PROD_W'(FULL_CIRCLE);
   assign pix_high      = pix_low + PROD_W'(FULL_CIRCLE);
   assign is_mark       = (mark_prod >= pix_low) && (mark_prod < pix_high);
   assign color_c       = is_mark ? mark_ff : fill_ff;

   // result byte
   assign rsp_data_in = in_pixel_c ? encode_byte(color_c, byte_c) : 8'h00;
   assign rsp_last_in = last_c;

   // counter advance
   always_comb begin
      frame_position_in    = pos_c;
      pixel_counter_in     = pix_c;
      byte_within_pixel_in = byte_c;
      if (last_c) begin
         frame_position_in    = '0;
         pixel_counter_in     = '0;
         byte_within_pixel_in = '0;
      end else begin
         if (in_pixel_c) begin
            if (byte_c == BYTE_W'(BYTES_PER_PIXEL - 1)) begin
               byte_within_pixel_in = '0;
               pixel_counter_in     = pix_c + PIX_W'(1);
            end else begin
               byte_within_pixel_in = byte_c + BYTE_W'(1);
            end
         end
         frame_position_in = pos_c + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_position_ff    <= '0;
         pixel_counter_ff     <= '0;
         byte_within_pixel_ff <= '0;
      end else if (req_xfer) begin
         frame_position_ff    <= frame_position_in;
         pixel_counter_ff     <= pixel_counter_in;
         byte_within_pixel_ff <= byte_within_pixel_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_last_byte = rsp_last_ff;

   // checks
`include "led_ring_spi_frame_encoder_macros.svh"

   `LRSFE_ASSERT(a_pos_range, frame_position_ff <= POS_W'(FRAME_BYTES - 1), "frame position past end")
   `LRSFE_ASSERT(a_byte_range, byte_within_pixel_ff < BYTE_W'(BYTES_PER_PIXEL), "pixel byte index out of range")
   `LRSFE_ASSERT(a_last_wraps, req_xfer && last_c |=> frame_position_ff == '0, "frame did not wrap after last byte")
   `LRSFE_ASSERT_ALWAYS(a_latch_zero, rsp_valid_ff && rsp_last_ff |-> rsp_data_ff == 8'h00, "last latch byte not zero")

endmodule
